// ----- hdl/assert_macros.svh -----
// assertion macros shared by the formatter rtl
// no dependencies; clock and reset names are fixed to i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define RDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rdf_pkg.sv -----
// shared constants, types and helper functions of the radix digit formatter
// no dependencies
package rdf_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = 7;
    localparam int VAL_W   = 64;
    localparam int CNT_W   = $clog2(VAL_W);
    localparam int BASE_W  = 6;
    localparam int RADIX_W = 5;
    localparam int CHAR_W  = 8;
    localparam int MOD_W   = 3;

    localparam logic [BASE_W-1:0]  BASE_MIN  = 6'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX  = 6'd26;
    localparam logic [LEN_W-1:0]   LEN_MIN   = 7'd2;
    localparam logic [LEN_W-1:0]   LEN_MAX   = 7'd64;
    localparam logic [LEN_W-1:0]   LEN_RESET = 7'd20;
    localparam logic [MOD_W-1:0]   GROUP_TOP = 3'd4;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;

    typedef struct packed {
        logic                 start;
        logic [VAL_W-1:0]     dividend;
        logic [RADIX_W-1:0]   divisor;
    } t_div_ctl;

    typedef struct packed {
        logic                 done;
        logic [VAL_W-1:0]     quotient;
        logic [RADIX_W-1:0]   remainder;
    } t_div_res;

    // digit value to ascii, 0-9 then A-P
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 5'd10) begin
            c = CH_ZERO + {3'b000, d};
        end else begin
            c = CH_A + {3'b000, d} - 8'd10;
        end
        return c;
    endfunction

    // v mod 5 using 16 = 1 (mod 5)
    function automatic logic [MOD_W-1:0] mod5(input logic [LEN_W-1:0] v);
        logic [4:0] s;
        s = {2'b00, v[6:4]} + {1'b0, v[3:0]};
        priority if (s >= 5'd20) begin
            s = s - 5'd20;
        end else if (s >= 5'd15) begin
            s = s - 5'd15;
        end else if (s >= 5'd10) begin
            s = s - 5'd10;
        end else if (s >= 5'd5) begin
            s = s - 5'd5;
        end
        return s[MOD_W-1:0];
    endfunction

    // buffer length saturated into the supported range
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        priority if (v < LEN_MIN) begin
            r = LEN_MIN;
        end else if (v > LEN_MAX) begin
            r = LEN_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hdl/rdf_if.sv -----
// valid/ready channels of the formatter: input word and result word
// depends on rdf_pkg for field widths
interface rdf_in_if;
    logic                         valid;
    logic                         ready;
    logic [rdf_pkg::VAL_W-1:0]    value;
    logic [rdf_pkg::BASE_W-1:0]   base;

    modport source (output valid, output value, output base, input ready);
    modport sink   (input valid, input value, input base, output ready);
endinterface

interface rdf_out_if;
    logic                         valid;
    logic                         ready;
    logic [rdf_pkg::CHAR_W-1:0]   char_code;
    logic [rdf_pkg::ADDR_W-1:0]   char_index;
    logic                         last;
    logic [rdf_pkg::LEN_W-1:0]    digit_count;
    logic                         bad_base;
    logic                         overflow;

    modport source (output valid, output char_code, output char_index, output last,
                    output digit_count, output bad_base, output overflow, input ready);
    modport sink   (input valid, input char_code, input char_index, input last,
                    input digit_count, input bad_base, input overflow, output ready);
endinterface

// ----- hdl/rdf_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module rdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/rdf_divider.sv -----
// bit-serial restoring divider: 64-bit dividend by a 5-bit radix
// depends on rdf_pkg and assert_macros.svh
`include "assert_macros.svh"

module rdf_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdf_pkg::t_div_ctl i_ctl,
    output rdf_pkg::t_div_res o_res
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [rdf_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [rdf_pkg::VAL_W-1:0]     r_quo, n_quo;
    logic [rdf_pkg::RADIX_W-1:0]   r_rem, n_rem;
    logic [rdf_pkg::RADIX_W-1:0]   r_div, n_div;
    logic [rdf_pkg::RADIX_W:0]     trial;
    logic [rdf_pkg::RADIX_W:0]     diff;
    logic                          fits;

    // one quotient bit per cycle, msb first
    assign trial = {r_rem, r_quo[rdf_pkg::VAL_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = (trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_ctl.dividend;
            n_rem  = '0;
            n_div  = i_ctl.divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[rdf_pkg::VAL_W-2:0], fits};
            n_rem = fits ? diff[rdf_pkg::RADIX_W-1:0] : trial[rdf_pkg::RADIX_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == rdf_pkg::CNT_W'(rdf_pkg::VAL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

    `RDF_ASSERT_NEXT(a_div_start, i_ctl.start, r_busy && (r_cnt == '0),
                     "divider did not start")
    `RDF_ASSERT(a_div_done, r_done |-> !r_busy, "divider done while still busy")
    `RDF_ASSERT(a_div_rem, r_busy |-> (r_rem < r_div), "partial remainder not below divisor")

endmodule

// ----- hdl/radix_digit_formatter_unit.sv -----
// top level of the radix digit formatter: sequencer, text store and output register
// depends on rdf_pkg, rdf_if, rdf_ram, rdf_divider and assert_macros.svh
// each significant digit costs a full divider run, each padded position a store write, and each character
// emitted a store read and an output register load (plus output stalls)
// throughput: one word at a time, input not ready until the last character is taken
// reset (synchronous, active low) returns to idle and sets buffer_length to 20
`include "assert_macros.svh"

module radix_digit_formatter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rdf_pkg::LEN_W-1:0]   i_cfg_data,
    rdf_in_if.sink                      i_word,
    rdf_out_if.source                   o_word
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input word
    localparam logic [2:0] S_SPC  = 3'd1;  // group space if due, kick divider
    localparam logic [2:0] S_DIV  = 3'd2;  // divider running
    localparam logic [2:0] S_DIG  = 3'd3;  // store one digit
    localparam logic [2:0] S_PAD  = 3'd4;  // fill left part with zeros and spaces
    localparam logic [2:0] S_RD   = 3'd5;  // read the store
    localparam logic [2:0] S_LD   = 3'd6;  // load output register
    localparam logic [2:0] S_OUT  = 3'd7;  // result word on the output

    logic [2:0]                    r_state, n_state;
    logic [rdf_pkg::LEN_W-1:0]     r_len, n_len;
    logic [rdf_pkg::ADDR_W-1:0]    r_last_idx, n_last_idx;
    logic [rdf_pkg::ADDR_W-1:0]    r_wpos, n_wpos;      // one past next text slot
    logic [rdf_pkg::MOD_W-1:0]     r_wmod, n_wmod;      // r_wpos mod 5
    logic [rdf_pkg::VAL_W-1:0]     r_work, n_work;
    logic [rdf_pkg::RADIX_W-1:0]   r_base, n_base;
    logic [rdf_pkg::LEN_W-1:0]     r_dcnt, n_dcnt;
    logic                          r_ovf, n_ovf;
    logic [rdf_pkg::ADDR_W-1:0]    r_idx, n_idx;
    logic [rdf_pkg::CHAR_W-1:0]    r_code, n_code;
    logic                          r_olast, n_olast;
    logic                          r_obad, n_obad;
    logic                          r_ovalid, n_ovalid;

    logic                          in_acc;
    logic                          base_ok;
    logic [rdf_pkg::LEN_W-1:0]     eff_len;
    logic [rdf_pkg::LEN_W-1:0]     len_m1;
    logic [rdf_pkg::MOD_W-1:0]     wmod_dec;
    logic                          ram_we;
    logic [rdf_pkg::ADDR_W-1:0]    ram_waddr;
    logic [rdf_pkg::CHAR_W-1:0]    ram_wdata;
    logic [rdf_pkg::CHAR_W-1:0]    ram_rdata;
    rdf_pkg::t_div_ctl             div_ctl;
    rdf_pkg::t_div_res             div_res;

    // text store, written right to left, read left to right
    rdf_ram #(
        .WIDTH (rdf_pkg::CHAR_W),
        .DEPTH (rdf_pkg::MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // shared divider, one digit per run
    rdf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .o_res   (div_res)
    );

    assign i_word.ready = (r_state == S_IDLE);
    assign in_acc       = i_word.valid && (r_state == S_IDLE);
    assign base_ok      = (i_word.base >= rdf_pkg::BASE_MIN) &&
                          (i_word.base <= rdf_pkg::BASE_MAX);
    assign eff_len      = rdf_pkg::clamp_len(r_len);
    assign len_m1       = eff_len - 1'b1;
    assign wmod_dec     = (r_wmod == '0) ? rdf_pkg::GROUP_TOP : (r_wmod - 1'b1);
    assign ram_waddr    = r_wpos - 1'b1;

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_last_idx = r_last_idx;
        n_wpos     = r_wpos;
        n_wmod     = r_wmod;
        n_work     = r_work;
        n_base     = r_base;
        n_dcnt     = r_dcnt;
        n_ovf      = r_ovf;
        n_idx      = r_idx;
        n_code     = r_code;
        n_olast    = r_olast;
        n_obad     = r_obad;
        n_ovalid   = r_ovalid;
        ram_we     = 1'b0;
        ram_wdata  = rdf_pkg::CH_SPACE;
        div_ctl.start    = 1'b0;
        div_ctl.dividend = r_work;
        div_ctl.divisor  = r_base;

        // config must only be written while idle; the block itself does not enforce this
        if (i_cfg_we) begin
            n_len = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_dcnt = '0;
                    n_ovf  = 1'b0;
                    n_idx  = '0;
                    if (!base_ok) begin
                        // single error word, nothing else
                        n_code   = rdf_pkg::CH_NUL;
                        n_olast  = 1'b1;
                        n_obad   = 1'b1;
                        n_ovalid = 1'b1;
                        n_state  = S_OUT;
                    end else begin
                        n_last_idx = len_m1[rdf_pkg::ADDR_W-1:0];
                        n_wpos     = len_m1[rdf_pkg::ADDR_W-1:0];
                        n_wmod     = rdf_pkg::mod5(len_m1);
                        n_work     = i_word.value;
                        n_base     = i_word.base[rdf_pkg::RADIX_W-1:0];
                        n_olast    = 1'b0;
                        n_obad     = 1'b0;
                        n_state    = S_SPC;
                    end
                end
            end
            S_SPC: begin
                // group separator lands before the next digit
                if ((r_wpos != '0) && (r_wmod == '0)) begin
                    ram_we = 1'b1;
                    n_wpos = r_wpos - 1'b1;
                    n_wmod = rdf_pkg::GROUP_TOP;
                end
                div_ctl.start = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                n_dcnt = r_dcnt + 1'b1;
                n_work = div_res.quotient;
                if (r_wpos != '0) begin
                    ram_we    = 1'b1;
                    ram_wdata = rdf_pkg::digit_char(div_res.remainder);
                    n_wpos    = r_wpos - 1'b1;
                    n_wmod    = wmod_dec;
                end else begin
                    // no room left, most significant digits drop
                    n_ovf = 1'b1;
                end
                n_state = (div_res.quotient != '0) ? S_SPC : S_PAD;
            end
            S_PAD: begin
                if (r_wpos != '0) begin
                    ram_we    = 1'b1;
                    ram_wdata = (r_wmod == '0) ? rdf_pkg::CH_SPACE : rdf_pkg::CH_ZERO;
                    n_wpos    = r_wpos - 1'b1;
                    n_wmod    = wmod_dec;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                // final position is the terminator, never stored
                n_olast  = (r_idx == r_last_idx);
                n_code   = (r_idx == r_last_idx) ? rdf_pkg::CH_NUL : ram_rdata;
                n_ovalid = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (o_word.ready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= rdf_pkg::LEN_RESET;
            r_wpos   <= '0;
            r_wmod   <= '0;
            r_work   <= '0;
            r_dcnt   <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_olast  <= 1'b0;
            r_obad   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_wpos   <= n_wpos;
            r_wmod   <= n_wmod;
            r_work   <= n_work;
            r_dcnt   <= n_dcnt;
            r_ovf    <= n_ovf;
            r_idx    <= n_idx;
            r_olast  <= n_olast;
            r_obad   <= n_obad;
            r_ovalid <= n_ovalid;
        end
        r_last_idx <= n_last_idx;
        r_base     <= n_base;
        r_code     <= n_code;
    end

    // output register drives the result word
    assign o_word.valid       = r_ovalid;
    assign o_word.char_code   = r_code;
    assign o_word.char_index  = r_idx;
    assign o_word.last        = r_olast;
    assign o_word.digit_count = r_olast ? r_dcnt : '0;
    assign o_word.bad_base    = r_obad;
    assign o_word.overflow    = r_olast && r_ovf;

    `RDF_ASSERT(a_out_excl, !(o_word.valid && i_word.ready), "result pending while input ready")
    `RDF_ASSERT(a_last_idx,
                (o_word.valid && o_word.last && !o_word.bad_base) |->
                (o_word.char_index == r_last_idx),
                "terminator not at final position")
    `RDF_ASSERT_NEXT(a_pad_step, (r_state == S_PAD) && (r_wpos != '0),
                     r_wpos == ($past(r_wpos) - 1'b1), "pad did not advance")

endmodule

// ----- tb/sv/radix_digit_formatter_unit_tb.sv -----
// self-checking bench for radix_digit_formatter_unit: converts random and corner numbers,
// predicts every character word and compares it with what the block emits
// depends on rdf_pkg, rdf_if and the formatter rtl
module radix_digit_formatter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GROUP_SPAN = 5;     // every fifth position is a space
    localparam int HOLD_CYCLES = 2500; // long receiver hold-off

    typedef struct packed {
        logic [rdf_pkg::CHAR_W-1:0] ch;
        logic [rdf_pkg::ADDR_W-1:0] idx;
        logic                       last;
        logic [rdf_pkg::LEN_W-1:0]  count;
        logic                       bad;
        logic                       ovf;
    } t_char_word;

    typedef struct packed {
        logic [rdf_pkg::VAL_W-1:0]  number;
        logic [rdf_pkg::BASE_W-1:0] radix;
    } t_number_job;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [rdf_pkg::LEN_W-1:0] cfg_data = '0;

    rdf_in_if  in_bus ();
    rdf_out_if out_bus ();

    radix_digit_formatter_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_word     (in_bus),
        .o_word     (out_bus)
    );

    t_number_job               pending_numbers[$];
    t_char_word                expected_chars[$];
    logic [rdf_pkg::LEN_W-1:0] len_setting = rdf_pkg::LEN_RESET;
    int unsigned               err_count = 0;
    int unsigned               words_taken = 0;
    int unsigned               burst_left = 0;
    int unsigned               gap_left = 0;
    logic                      hold_off = 1'b0;
    logic [15:0]               ready_mask = '1;
    int unsigned               mask_age = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // expected text of one number: right-aligned digits, zero padding, spaces, nul; one error word for a bad radix
    function automatic void format_digits(input logic [rdf_pkg::VAL_W-1:0] number,
                                          input logic [rdf_pkg::BASE_W-1:0] radix,
                                          input logic [rdf_pkg::LEN_W-1:0] len_reg);
        logic [rdf_pkg::CHAR_W-1:0] text [0:63];
        logic [rdf_pkg::VAL_W-1:0]  rest;
        logic [rdf_pkg::VAL_W-1:0]  rem;
        logic [rdf_pkg::LEN_W-1:0]  len_sat;
        int unsigned                len, pos, n_digits, i;
        logic                       lost;
        t_char_word                 w;
        if (radix < rdf_pkg::BASE_MIN || radix > rdf_pkg::BASE_MAX) begin
            w = '{ch: rdf_pkg::CH_NUL, idx: '0, last: 1'b1, count: '0, bad: 1'b1,
                  ovf: 1'b0};
            expected_chars.push_back(w);
            return;
        end
        len_sat = (len_reg < rdf_pkg::LEN_MIN) ? rdf_pkg::LEN_MIN :
                  (len_reg > rdf_pkg::LEN_MAX) ? rdf_pkg::LEN_MAX : len_reg;
        len = 32'(len_sat);
        rest = number;
        pos = len - 1;
        n_digits = 0;
        lost = 1'b0;
        do begin
            rem = rest % {58'd0, radix};
            rest = rest / {58'd0, radix};
            n_digits++;
            if (pos > 0 && pos % GROUP_SPAN == 0) begin
                text[pos-1] = rdf_pkg::CH_SPACE;
                pos--;
            end
            if (pos > 0) begin
                text[pos-1] = (rem < 10) ? rdf_pkg::CH_ZERO + rem[7:0]
                                         : rdf_pkg::CH_A + rem[7:0] - 8'd10;
                pos--;
            end else begin
                lost = 1'b1;   // most significant digits fall off the left edge
            end
        end while (rest != 0);
        while (pos > 0) begin
            text[pos-1] = (pos % GROUP_SPAN == 0) ? rdf_pkg::CH_SPACE : rdf_pkg::CH_ZERO;
            pos--;
        end
        text[len-1] = rdf_pkg::CH_NUL;
        for (i = 0; i < len; i++) begin
            w.ch    = text[i];
            w.idx   = rdf_pkg::ADDR_W'(i);
            w.last  = (i == len - 1);
            w.count = (i == len - 1) ? rdf_pkg::LEN_W'(n_digits) : '0;
            w.bad   = 1'b0;
            w.ovf   = (i == len - 1) && lost;
            expected_chars.push_back(w);
        end
    endfunction

    function automatic t_number_job random_job();
        t_number_job j;
        int unsigned w;
        w = $urandom_range(0, 64);
        j.number = {$urandom, $urandom};
        if (w < 64) begin
            j.number = j.number & ((64'd1 << w) - 64'd1);
        end
        if ($urandom_range(0, 19) == 0) begin
            j.number = '1;
        end
        j.radix = ($urandom_range(0, 6) == 0) ? rdf_pkg::BASE_W'($urandom_range(0, 63))
                                              : rdf_pkg::BASE_W'($urandom_range(2, 26));
        return j;
    endfunction

    task automatic push_job(input logic [rdf_pkg::VAL_W-1:0] number,
                            input logic [rdf_pkg::BASE_W-1:0] radix);
        pending_numbers.push_back('{number: number, radix: radix});
    endtask

    task automatic add_random(input int n);
        repeat (n) pending_numbers.push_back(random_job());
    endtask

    // nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (pending_numbers.size() != 0 || in_bus.valid || expected_chars.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_length(input logic [rdf_pkg::LEN_W-1:0] v);
        wait_idle();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        len_setting = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // sender: bursts of words with random gaps, predicts on acceptance
    always @(posedge clk) begin : feed_words
        t_number_job job;
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                format_digits(in_bus.value, in_bus.base, len_setting);
                words_taken++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_bus.valid <= 1'b0;
                end else if (pending_numbers.size() != 0) begin
                    job = pending_numbers.pop_front();
                    in_bus.valid <= 1'b1;
                    in_bus.value <= job.number;
                    in_bus.base <= job.radix;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating ready pattern, re-chosen whenever its age counter runs out
    always @(posedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (mask_age == 0) begin
                case ($urandom_range(0, 2))
                    0: ready_mask = '1;
                    1: ready_mask = 16'h5555;
                    default: ready_mask = 16'($urandom_range(0, 65535)) | 16'h8001;
                endcase
                mask_age = $urandom_range(50, 400);
            end else begin
                ready_mask = {ready_mask[0], ready_mask[15:1]};
                mask_age--;
            end
            out_bus.ready <= ready_mask[0] && !hold_off;
        end
    end

    // one long receiver hold-off while the sender keeps offering words
    initial begin
        wait (words_taken >= 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // compare each accepted character word with the oldest prediction
    always @(posedge clk) begin : check_chars
        t_char_word want;
        t_char_word got;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            got = '{ch: out_bus.char_code, idx: out_bus.char_index, last: out_bus.last,
                    count: out_bus.digit_count, bad: out_bus.bad_base, ovf: out_bus.overflow};
            if (expected_chars.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t unexpected word: code %h idx %0d last %b cnt %0d bad %b ovf %b",
                             $realtime, got.ch, got.idx, got.last, got.count, got.bad, got.ovf);
            end else begin
                want = expected_chars.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"%0t mismatch: exp code %h idx %0d last %b cnt %0d bad %b ovf %b",
                                  " / got code %h idx %0d last %b cnt %0d bad %b ovf %b"},
                                 $realtime, want.ch, want.idx, want.last, want.count, want.bad,
                                 want.ovf, got.ch, got.idx, got.last, got.count, got.bad,
                                 got.ovf);
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int k;
        in_bus.valid = 1'b0;
        in_bus.value = '0;
        in_bus.base = '0;
        out_bus.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset length of 20: corner numbers, extreme radices, bad radices
        push_job(64'd0, 6'd10);
        push_job(64'd1, 6'd2);
        push_job('1, 6'd2);                      // 64 digits, most are dropped
        push_job('1, 6'd26);
        push_job('1, 6'd16);
        push_job('1, 6'd10);
        push_job(64'd25, 6'd26);                 // highest digit letter
        push_job(64'd35, 6'd26);
        push_job(64'd10, 6'd11);
        push_job(64'h8000_0000_0000_0000, 6'd2);
        push_job(64'h5555_5555_5555_5555, 6'd3);
        push_job(64'd99999, 6'd10);              // digits across a space
        push_job('1, 6'd0);
        push_job(64'hAAAA_AAAA_AAAA_AAAA, 6'd1);
        push_job(64'd7, 6'd27);
        push_job('1, 6'd63);
        add_random(10);

        set_length(7'd2);                        // one text position only
        push_job(64'd0, 6'd10);
        push_job(64'd10, 6'd10);
        push_job('1, 6'd2);
        add_random(10);

        set_length(7'd64);
        push_job('1, 6'd2);
        push_job(64'd0, 6'd26);
        add_random(15);

        set_length(7'd0);                        // saturates to the shortest text
        add_random(8);
        set_length(7'd127);                      // saturates to the longest text
        add_random(12);
        set_length(7'd1);
        add_random(8);
        set_length(7'd65);
        add_random(10);
        set_length(7'd5);
        add_random(10);
        set_length(7'd6);                        // space right before the nul
        push_job(64'd12345, 6'd10);
        push_job('1, 6'd25);
        add_random(10);
        for (k = 0; k < 3; k++) begin
            set_length(rdf_pkg::LEN_W'($urandom_range(2, 64)));
            add_random(8);
        end

        wait_idle();
        repeat (100) @(posedge clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
